// ===== src/rnsh_pkg.sv =====
`default_nettype none

package rnsh_pkg;

    // Default widths of coordinates and of the ray parameter t.
    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed widths of the length register and of the reported distance.
    localparam int LEN_BITS       = 12;
    localparam int DIST_BITS      = 16;
    localparam int DIST_FRAC_BITS = 4;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RAY_ORIGIN_X = 3'd0,
        CFG_RAY_ORIGIN_Y = 3'd1,
        CFG_RAY_END_X    = 3'd2,
        CFG_RAY_END_Y    = 3'd3,
        CFG_RAY_LENGTH   = 3'd4
    } cfg_index_t;

    // Register values after reset.
    localparam int RAY_END_Y_RESET  = -3200;
    localparam int RAY_LENGTH_RESET = 200;

endpackage

`default_nettype wire

// ===== src/ray_nearest_segment_hit_core.sv =====
`default_nettype none

// Casts one ray, set by the configuration registers, against a stream of boundary
// segments and reports the nearest proper crossing when the segment flagged as last
// has been processed. A segment is worked on by one shared signed multiplier and a
// restoring divider that yields one quotient bit per cycle; s_ready is high only
// while the core is idle, so a new segment is taken only once the previous one is done.
// A segment that misses skips the divider; a hit runs it, and a new nearest hit
// also computes the hit point. After the last segment of a pass the result register
// is loaded, once the previous result has been taken. Register writes must only be
// made while the core is idle.
module ray_nearest_segment_hit_core
    import rnsh_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0]           cfg_index,
    input  wire logic [((COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS)-1:0] cfg_wr_data,

    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire logic signed [COORD_BITS-1:0]        s_seg_start_x,
    input  wire logic signed [COORD_BITS-1:0]        s_seg_start_y,
    input  wire logic signed [COORD_BITS-1:0]        s_seg_end_x,
    input  wire logic signed [COORD_BITS-1:0]        s_seg_end_y,
    input  wire logic                                s_last_segment,

    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      logic                                m_hit_found,
    output      logic [DIST_BITS-1:0]                m_hit_distance,
    output      logic signed [COORD_BITS-1:0]        m_hit_x,
    output      logic signed [COORD_BITS-1:0]        m_hit_y
);

    // Widths: differences, cross products, multiplier operands, rounding sums.
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * COORD_BITS + 3;
    localparam int MW0   = (DW > FRACTION_BITS + 1) ? DW : FRACTION_BITS + 1;
    localparam int MW    = (MW0 > LEN_BITS + 1) ? MW0 : LEN_BITS + 1;
    localparam int PRW   = 2 * MW + 1;
    localparam int DSW   = 2 * MW + DIST_FRAC_BITS;
    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [PRW-1:0] RND_HALF = PRW'(1) << (FRACTION_BITS - 1);
    localparam logic [DSW-1:0] DST_HALF = DSW'(1) << (FRACTION_BITS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(6);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_NORM,
        S_TEST,
        S_DIV,
        S_CMP,
        S_PX,
        S_PY,
        S_PW,
        S_TAIL,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic signed [COORD_BITS-1:0] ray_origin_x_reg, ray_origin_y_reg;
    logic signed [COORD_BITS-1:0] ray_end_x_reg, ray_end_y_reg;
    logic [LEN_BITS-1:0]          ray_length_reg;

    // Pass state.
    logic [FRACTION_BITS:0]       best_fraction_reg;
    logic signed [COORD_BITS-1:0] best_point_x_reg, best_point_y_reg;
    logic                         any_hit_reg;

    // Working registers of one segment.
    logic signed [DW-1:0]         a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;
    logic                         last_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic signed [PW-1:0]         den_reg, tn_reg, un_reg;
    logic [PW-1:0]                rem_reg;
    logic [FRACTION_BITS-1:0]     q_reg;
    logic signed [2*MW-1:0]       prod_reg;

    // Output register.
    logic                         m_valid_reg;
    logic                         m_hit_found_reg;
    logic [DIST_BITS-1:0]         m_hit_distance_reg;
    logic signed [COORD_BITS-1:0] m_hit_x_reg, m_hit_y_reg;

    // Ray direction as magnitude and sign, for the hit point.
    logic signed [DW-1:0] ray_dx, ray_dy;
    logic                 dx_neg, dy_neg;
    logic [DW-1:0]        dx_mag, dy_mag;

    always_comb begin
        ray_dx = DW'(ray_end_x_reg) - DW'(ray_origin_x_reg);
        ray_dy = DW'(ray_end_y_reg) - DW'(ray_origin_y_reg);
        dx_neg = ray_dx[DW-1];
        dy_neg = ray_dy[DW-1];
        dx_mag = dx_neg ? $unsigned(-ray_dx) : $unsigned(ray_dx);
        dy_mag = dy_neg ? $unsigned(-ray_dy) : $unsigned(ray_dy);
    end

    // Operand selection for the shared multiplier.
    logic signed [MW-1:0] op_a, op_b;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_MUL: begin
                unique case (cnt_reg)
                    CNT_W'(0): begin op_a = MW'(a_reg); op_b = MW'(c_reg); end
                    CNT_W'(1): begin op_a = MW'(b_reg); op_b = MW'(d_reg); end
                    CNT_W'(2): begin op_a = MW'(e_reg); op_b = MW'(c_reg); end
                    CNT_W'(3): begin op_a = MW'(f_reg); op_b = MW'(d_reg); end
                    CNT_W'(4): begin op_a = MW'(b_reg); op_b = MW'(e_reg); end
                    CNT_W'(5): begin op_a = MW'(a_reg); op_b = MW'(f_reg); end
                    default: begin op_a = '0; op_b = '0; end
                endcase
            end
            S_PX: begin
                op_a = MW'($signed({1'b0, q_reg}));
                op_b = MW'($signed({1'b0, dx_mag}));
            end
            S_PY: begin
                op_a = MW'($signed({1'b0, q_reg}));
                op_b = MW'($signed({1'b0, dy_mag}));
            end
            S_TAIL, S_EMIT: begin
                op_a = MW'($signed({1'b0, best_fraction_reg}));
                op_b = MW'($signed({1'b0, ray_length_reg}));
            end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // Accumulation of the cross products: even steps load, odd steps subtract.
    logic signed [PW-1:0] prod_ext;
    assign prod_ext = PW'(prod_reg);

    // Hit point from the last product: round half away from zero, then add origin.
    logic [PRW-1:0]               pt_rnd;
    logic signed [DW-1:0]         pt_mag, pt_base, pt_sum;
    logic                         pt_neg;
    logic [COORD_BITS-1:0]        pt_next;

    always_comb begin
        pt_rnd  = PRW'($unsigned(prod_reg)) + RND_HALF;
        pt_mag  = $signed(pt_rnd[FRACTION_BITS +: DW]);
        pt_neg  = (state_reg == S_PY) ? dx_neg : dy_neg;
        pt_base = (state_reg == S_PY) ? DW'(ray_origin_x_reg) : DW'(ray_origin_y_reg);
        pt_sum  = pt_neg ? (pt_base - pt_mag) : (pt_base + pt_mag);
        pt_next = pt_sum[COORD_BITS-1:0];
    end

    // Distance: t times length, scaled to four fraction bits and rounded; the full length without a hit.
    logic [DSW-1:0]       dist_sum;
    logic [DIST_BITS-1:0] dist_next;

    always_comb begin
        dist_sum  = (DSW'($unsigned(prod_reg)) << DIST_FRAC_BITS) + DST_HALF;
        dist_next = any_hit_reg ? dist_sum[FRACTION_BITS +: DIST_BITS]
                                : {ray_length_reg, {DIST_FRAC_BITS{1'b0}}};
    end

    // Divider step: shift the partial remainder and subtract where it fits.
    logic [PW-1:0] den_u, rem_shift;
    logic          rem_ge;

    always_comb begin
        den_u     = $unsigned(den_reg);
        rem_shift = {rem_reg[PW-2:0], 1'b0};
        rem_ge    = (rem_shift >= den_u);
    end

    logic hit_test;
    assign hit_test = (tn_reg > 0) && (tn_reg < den_reg) && (un_reg > 0) && (un_reg < den_reg);

    // Shared multiplier with its output register.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    // Sequencer, pass state, configuration and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            ray_origin_x_reg  <= '0;
            ray_origin_y_reg  <= '0;
            ray_end_x_reg     <= '0;
            ray_end_y_reg     <= COORD_BITS'(RAY_END_Y_RESET);
            ray_length_reg    <= LEN_BITS'(RAY_LENGTH_RESET);
            best_fraction_reg <= FRAC_ONE;
            best_point_x_reg  <= '0;
            best_point_y_reg  <= '0;
            any_hit_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
            cnt_reg           <= '0;
        end else begin
            // Register writes.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_RAY_ORIGIN_X: ray_origin_x_reg <= cfg_wr_data[COORD_BITS-1:0];
                    CFG_RAY_ORIGIN_Y: ray_origin_y_reg <= cfg_wr_data[COORD_BITS-1:0];
                    CFG_RAY_END_X:    ray_end_x_reg    <= cfg_wr_data[COORD_BITS-1:0];
                    CFG_RAY_END_Y:    ray_end_y_reg    <= cfg_wr_data[COORD_BITS-1:0];
                    CFG_RAY_LENGTH:   ray_length_reg   <= cfg_wr_data[LEN_BITS-1:0];
                    default: ;
                endcase
            end

            // The result leaves on a completed transfer; in S_EMIT the load decides.
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        a_reg    <= DW'(ray_origin_x_reg) - DW'(ray_end_x_reg);
                        b_reg    <= DW'(ray_origin_y_reg) - DW'(ray_end_y_reg);
                        c_reg    <= DW'(s_seg_start_y) - DW'(s_seg_end_y);
                        d_reg    <= DW'(s_seg_start_x) - DW'(s_seg_end_x);
                        e_reg    <= DW'(ray_origin_x_reg) - DW'(s_seg_start_x);
                        f_reg    <= DW'(ray_origin_y_reg) - DW'(s_seg_start_y);
                        last_reg <= s_last_segment;
                        cnt_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    // The product of step k is folded in during step k+1.
                    unique case (cnt_reg)
                        CNT_W'(1): den_reg <= prod_ext;
                        CNT_W'(2): den_reg <= den_reg - prod_ext;
                        CNT_W'(3): tn_reg  <= prod_ext;
                        CNT_W'(4): tn_reg  <= tn_reg - prod_ext;
                        CNT_W'(5): un_reg  <= prod_ext;
                        CNT_W'(6): un_reg  <= un_reg - prod_ext;
                        default: ;
                    endcase
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == MUL_LAST) begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: begin
                    // Make the denominator positive; a zero one fails the test.
                    if (den_reg < 0) begin
                        den_reg <= -den_reg;
                        tn_reg  <= -tn_reg;
                        un_reg  <= -un_reg;
                    end
                    state_reg <= S_TEST;
                end
                S_TEST: begin
                    if (hit_test) begin
                        any_hit_reg <= 1'b1;
                        rem_reg     <= $unsigned(tn_reg);
                        q_reg       <= '0;
                        cnt_reg     <= CNT_W'(FRACTION_BITS);
                        state_reg   <= S_DIV;
                    end else begin
                        state_reg <= S_TAIL;
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_ge ? (rem_shift - den_u) : rem_shift;
                    q_reg   <= {q_reg[FRACTION_BITS-2:0], rem_ge};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    // A tie keeps the earlier hit.
                    if ({1'b0, q_reg} < best_fraction_reg) begin
                        state_reg <= S_PX;
                    end else begin
                        state_reg <= S_TAIL;
                    end
                end
                S_PX: begin
                    state_reg <= S_PY;
                end
                S_PY: begin
                    best_point_x_reg <= pt_next;
                    state_reg        <= S_PW;
                end
                S_PW: begin
                    best_point_y_reg  <= pt_next;
                    best_fraction_reg <= {1'b0, q_reg};
                    state_reg         <= S_TAIL;
                end
                S_TAIL: begin
                    state_reg <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_hit_found_reg    <= any_hit_reg;
                        m_hit_distance_reg <= dist_next;
                        m_hit_x_reg        <= best_point_x_reg;
                        m_hit_y_reg        <= best_point_y_reg;
                        best_fraction_reg  <= FRAC_ONE;
                        best_point_x_reg   <= '0;
                        best_point_y_reg   <= '0;
                        any_hit_reg        <= 1'b0;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_hit_found    = m_hit_found_reg;
    assign m_hit_distance = m_hit_distance_reg;
    assign m_hit_x        = m_hit_x_reg;
    assign m_hit_y        = m_hit_y_reg;

    // The nearest t never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        best_fraction_reg <= FRAC_ONE)
        else $error("nearest fraction above one");

    // Without a hit in the pass the nearest state holds its cleared values.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !any_hit_reg |-> (best_fraction_reg == FRAC_ONE) && (best_point_x_reg == '0)
                         && (best_point_y_reg == '0))
        else $error("pass state changed without a hit");

    // The partial remainder stays below the divisor throughout the division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < den_u) && (den_reg > 0))
        else $error("divider remainder out of range");

    // A result without a hit reports the origin-free zero point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_found_reg) |-> (m_hit_x_reg == '0) && (m_hit_y_reg == '0))
        else $error("miss reported with a non-zero point");

    // No segment is taken while a finished pass waits for the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> !s_ready)
        else $error("segment accepted while a result is pending");

endmodule

`default_nettype wire
